// ===== sv/bsev_pkg.sv =====
// Shared types and constants for the B-spline surface evaluator.
// No dependencies; imported by bsev_basis, bspline_surface_evaluator, bsev_checker and testbench.
`default_nettype none

package bsev_pkg;

  // Fixed-point format of basis values
  localparam int FRAC_BITS  = 15;
  localparam int BASIS_W    = FRAC_BITS + 2;           // signed, holds +/-1.0
  localparam int KNOT_W     = 16;
  localparam int COORD_W    = 16;
  localparam int POINT_W    = 32;

  // Store geometry
  localparam int MAX_CTRL_U = 32;
  localparam int MAX_CTRL_V = 32;
  localparam int MAX_DEGREE = 7;
  localparam int LAST_W     = 5;
  localparam int DEG_W      = 3;
  localparam int KNOT_DEPTH = MAX_CTRL_U + 1;
  localparam int KADDR_W    = 6;
  localparam int NB_DEPTH   = MAX_CTRL_U + MAX_DEGREE + 1;
  localparam int NBADDR_W   = 6;
  localparam int CP_DEPTH   = MAX_CTRL_U * MAX_CTRL_V;
  localparam int CPADDR_W   = 10;
  localparam int CFG_W      = 5;

  localparam logic [KNOT_W-1:0] KNOT_ONE = KNOT_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    ACT_LOAD_U = 2'd0,
    ACT_LOAD_V = 2'd1,
    ACT_LOAD_P = 2'd2,
    ACT_EVAL   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_U_LAST = 2'd0,
    REG_V_LAST = 2'd1,
    REG_U_DEG  = 2'd2,
    REG_V_DEG  = 2'd3
  } cfg_reg_t;

  // Knot store write request
  typedef struct packed {
    logic               we;
    logic [KADDR_W-1:0] addr;
    logic [KNOT_W-1:0]  data;
  } kwr_t;

  // Basis evaluation start request
  typedef struct packed {
    logic               go;
    logic [COORD_W-1:0] coord;
    logic [LAST_W-1:0]  last;
    logic [DEG_W-1:0]   deg;
  } bstart_t;

endpackage

`default_nettype wire

// ===== sv/bsev_basis.sv =====
// One-direction Cox-de Boor basis unit: knot store, basis memory, serial divider.
// Depends on bsev_pkg.
`default_nettype none

module bsev_basis import bsev_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kwr_t                       kwr,
  input  wire bstart_t                    start,
  output logic                            busy,
  input  wire logic [NBADDR_W-1:0]        rd_addr,
  output logic signed [BASIS_W-1:0]       rd_data
);

  typedef enum logic [11:0] {
    B_IDLE  = 12'b000000000001,
    B_KREQ  = 12'b000000000010,
    B_KCAP  = 12'b000000000100,
    B_NREQ0 = 12'b000000001000,
    B_NREQ1 = 12'b000000010000,
    B_NCAP  = 12'b000000100000,
    B_INIT  = 12'b000001000000,
    B_MUL   = 12'b000010000000,
    B_DLD   = 12'b000100000000,
    B_DIV   = 12'b001000000000,
    B_DEND  = 12'b010000000000,
    B_WRITE = 12'b100000000000
  } bstate_t;

  typedef enum logic [1:0] {
    KS_ZERO  = 2'd0,
    KS_ONE   = 2'd1,
    KS_STORE = 2'd2
  } ksel_t;

  bstate_t state_r, state_nxt;

  logic [KNOT_W-1:0]   kst [0:KNOT_DEPTH-1];
  logic [KNOT_W-1:0]   kq_r;
  logic signed [BASIS_W-1:0] nbm [0:NB_DEPTH-1];
  logic signed [BASIS_W-1:0] nbq_r;

  logic [COORD_W-1:0]  coord_r;
  logic [LAST_W-1:0]   last_r;
  logic [DEG_W-1:0]    deg_r;
  logic [DEG_W-1:0]    d_r;
  logic [NBADDR_W-1:0] i_r;
  logic [1:0]          slot_r;
  ksel_t               ksel_r;
  logic [KNOT_W-1:0]   k_r [0:3];
  logic signed [BASIS_W-1:0] nbi_r, nbi1_r;
  logic                term_r;
  logic signed [31:0]  prod_r;
  logic signed [KNOT_W:0] den_r;
  logic [15:0]         rem_r, dsr_r;
  logic [30:0]         q_r;
  logic [4:0]          cnt_r;
  logic                neg_r;
  logic signed [31:0]  a_r, b_r;

  logic [KADDR_W-1:0]  kidx, kaddr;
  logic [KADDR_W-1:0]  mp1;
  logic [NBADDR_W-1:0] last_i, nb_raddr;
  logic [KNOT_W-1:0]   kval;
  logic signed [KNOT_W:0] u_s, diff, dd;
  logic signed [BASIS_W-1:0] fac, nb_wdata, clampv;
  logic signed [2*KNOT_W+1:0] prod_full;
  logic signed [31:0]  pabs, qs;
  logic signed [KNOT_W:0] dabs;
  logic signed [32:0]  sum;
  logic [16:0]         rem_s;
  logic                nb_we, in_span;

  assign busy    = (state_r != B_IDLE);
  assign rd_data = nbq_r;
  assign u_s     = $signed({1'b0, coord_r});
  assign mp1     = KADDR_W'(last_r) + KADDR_W'(1);
  assign last_i  = NBADDR_W'(last_r) + NBADDR_W'(deg_r) - NBADDR_W'(d_r);

  // Knot index for the current fetch slot: t[i], t[i+d], t[i+1], t[i+d+1]
  always_comb begin
    unique case (slot_r)
      2'd0: kidx = i_r;
      2'd1: kidx = i_r + KADDR_W'(d_r);
      2'd2: kidx = i_r + KADDR_W'(1);
      2'd3: kidx = i_r + KADDR_W'(d_r) + KADDR_W'(1);
      default: kidx = i_r;
    endcase
  end

  assign kaddr = (kidx >= KADDR_W'(deg_r) && kidx <= mp1) ? kidx - KADDR_W'(deg_r) : '0;

  always_comb begin
    unique case (ksel_r)
      KS_ZERO:  kval = '0;
      KS_ONE:   kval = KNOT_ONE;
      KS_STORE: kval = kq_r;
      default:  kval = '0;
    endcase
  end

  // Knot store: one write port from loads, one read port for fetches
  always_ff @(posedge clk) begin
    if (kwr.we) begin
      kst[kwr.addr] <= kwr.data;
    end
    kq_r <= kst[kaddr];
  end

  // Basis memory: internal reads in B_NREQ0/B_NREQ1, external reads otherwise
  always_comb begin
    priority case (state_r)
      B_NREQ0: nb_raddr = i_r;
      B_NREQ1: nb_raddr = i_r + NBADDR_W'(1);
      default: nb_raddr = rd_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nbm[i_r] <= nb_wdata;
    end
    nbq_r <= nbm[nb_raddr];
  end

  // Degree-0 span test, closed at u = 1.0 on the last nonempty span
  assign in_span = ((k_r[0] <= coord_r) && (coord_r < k_r[2])) ||
                   ((coord_r == KNOT_ONE) && (k_r[0] < k_r[2]) && (k_r[2] == KNOT_ONE));

  // Recursion term operands
  always_comb begin
    if (term_r) begin
      diff = $signed({1'b0, k_r[3]}) - u_s;
      fac  = nbi1_r;
      dd   = $signed({1'b0, k_r[3]}) - $signed({1'b0, k_r[2]});
    end else begin
      diff = u_s - $signed({1'b0, k_r[0]});
      fac  = nbi_r;
      dd   = $signed({1'b0, k_r[1]}) - $signed({1'b0, k_r[0]});
    end
  end

  assign prod_full = diff * fac;
  assign pabs  = prod_r[31] ? -prod_r : prod_r;
  assign dabs  = den_r[KNOT_W] ? -den_r : den_r;
  assign qs    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign rem_s = {rem_r, q_r[30]};
  assign sum   = {a_r[31], a_r} + {b_r[31], b_r};

  // Saturate the new basis value to +/-1.0
  always_comb begin
    if (sum > 33'sd32768) begin
      clampv = BASIS_W'(32768);
    end else if (sum < -33'sd32768) begin
      clampv = -BASIS_W'(32768);
    end else begin
      clampv = sum[BASIS_W-1:0];
    end
  end

  assign nb_we    = (state_r == B_INIT) || (state_r == B_WRITE);
  assign nb_wdata = (state_r == B_INIT) ? (in_span ? BASIS_W'(32768) : '0) : clampv;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (start.go) state_nxt = B_KREQ;
      B_KREQ:  state_nxt = B_KCAP;
      B_KCAP: begin
        if (slot_r != 2'd3) state_nxt = B_KREQ;
        else if (d_r == '0) state_nxt = B_INIT;
        else state_nxt = B_NREQ0;
      end
      B_NREQ0: state_nxt = B_NREQ1;
      B_NREQ1: state_nxt = B_NCAP;
      B_NCAP:  state_nxt = B_MUL;
      B_MUL: begin
        if (dd == '0 || fac == '0) state_nxt = term_r ? B_WRITE : B_MUL;
        else state_nxt = B_DLD;
      end
      B_DLD:   state_nxt = B_DIV;
      B_DIV:   if (cnt_r == 5'd30) state_nxt = B_DEND;
      B_DEND:  state_nxt = term_r ? B_WRITE : B_MUL;
      B_INIT, B_WRITE: begin
        if (i_r == last_i && d_r == deg_r) state_nxt = B_IDLE;
        else state_nxt = B_KREQ;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (start.go) begin
          coord_r <= start.coord;
          last_r  <= start.last;
          deg_r   <= start.deg;
          d_r     <= '0;
          i_r     <= '0;
          slot_r  <= '0;
          term_r  <= 1'b0;
        end
      end
      B_KREQ: begin
        if (kidx < KADDR_W'(deg_r)) ksel_r <= KS_ZERO;
        else if (kidx > mp1) ksel_r <= KS_ONE;
        else ksel_r <= KS_STORE;
      end
      B_KCAP: begin
        k_r[slot_r] <= kval;
        slot_r      <= slot_r + 2'd1;
      end
      B_NREQ0: ;
      B_NREQ1: nbi_r  <= nbq_r;
      B_NCAP:  nbi1_r <= nbq_r;
      B_MUL: begin
        prod_r <= prod_full[31:0];
        den_r  <= dd;
        if (dd == '0 || fac == '0) begin
          if (term_r) b_r <= '0;
          else a_r <= '0;
          term_r <= 1'b1;
        end
      end
      B_DLD: begin
        q_r   <= pabs[30:0];
        dsr_r <= dabs[15:0];
        rem_r <= '0;
        cnt_r <= '0;
        neg_r <= prod_r[31] ^ den_r[KNOT_W];
      end
      B_DIV: begin
        // Restoring division, one quotient bit per cycle
        if (rem_s >= {1'b0, dsr_r}) begin
          rem_r <= 16'(rem_s - {1'b0, dsr_r});
          q_r   <= {q_r[29:0], 1'b1};
        end else begin
          rem_r <= rem_s[15:0];
          q_r   <= {q_r[29:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
      end
      B_DEND: begin
        if (term_r) b_r <= qs;
        else a_r <= qs;
        term_r <= 1'b1;
      end
      B_INIT, B_WRITE: begin
        // Advance to the next element or level
        term_r <= 1'b0;
        if (i_r == last_i) begin
          i_r <= '0;
          d_r <= d_r + DEG_W'(1);
        end else begin
          i_r <= i_r + NBADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/bspline_surface_evaluator.sv =====
// Top level of the tensor-product B-spline surface evaluator.
// Depends on bsev_pkg and bsev_basis (one instance per direction).
`default_nettype none

// Load beats (knot or control point) are taken while the sequencer is idle. An
// evaluate beat runs both basis units side by side, then sums the (m+1)*(n+1)
// control point terms in one shared multiply-accumulate path reading the
// control point memories, each term passing through the read, weight, product
// and accumulate states. A basis unit works through m+p+1 degree-0 elements
// and, at each level d = 1..p, m+p+1-d elements, using its serial divider
// once per nonzero recursion term. The slower direction sets the basis time.
// A result waits in its output register while load beats keep being taken.
module bspline_surface_evaluator import bsev_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_action,
  input  wire logic [9:0]          in_entry_index,
  input  wire logic [KNOT_W-1:0]   in_knot_value,
  input  wire logic signed [31:0]  in_point_x,
  input  wire logic signed [31:0]  in_point_y,
  input  wire logic signed [31:0]  in_point_z,
  input  wire logic [COORD_W-1:0]  in_u_coord,
  input  wire logic [COORD_W-1:0]  in_v_coord,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       out_surf_x,
  output logic signed [31:0]       out_surf_y,
  output logic signed [31:0]       out_surf_z,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  typedef enum logic [6:0] {
    T_IDLE  = 7'b0000001,
    T_BASIS = 7'b0000010,
    T_RD    = 7'b0000100,
    T_WGT   = 7'b0001000,
    T_PRD   = 7'b0010000,
    T_ACC   = 7'b0100000,
    T_OUT   = 7'b1000000
  } tstate_t;

  tstate_t state_r, state_nxt;

  logic [LAST_W-1:0] u_last_r, v_last_r;
  logic [DEG_W-1:0]  u_deg_r, v_deg_r;

  logic signed [POINT_W-1:0] cx_mem [0:CP_DEPTH-1];
  logic signed [POINT_W-1:0] cy_mem [0:CP_DEPTH-1];
  logic signed [POINT_W-1:0] cz_mem [0:CP_DEPTH-1];
  logic signed [POINT_W-1:0] cx_q_r, cy_q_r, cz_q_r;

  logic [LAST_W-1:0]   i_r, j_r;
  logic [CPADDR_W-1:0] flat_r;
  logic signed [2*BASIS_W-1:0] wprod_r;
  logic signed [BASIS_W+POINT_W-1:0] px_r, py_r, pz_r;
  logic signed [43:0]  ax_r, ay_r, az_r;
  logic                out_valid_r;
  logic signed [31:0]  ox_r, oy_r, oz_r;

  logic      accept, is_eval, cp_we, out_load;
  action_t   act;
  kwr_t      ukwr, vkwr;
  bstart_t   ustart, vstart;
  logic      u_busy, v_busy;
  logic signed [BASIS_W-1:0] nu_q, nv_q;
  logic signed [2*BASIS_W-1:0] wbias;
  logic signed [BASIS_W-1:0] w;
  logic signed [BASIS_W+POINT_W-1:0] tx, ty, tz;

  assign in_stall = (state_r != T_IDLE);
  assign accept   = in_valid && !in_stall;
  assign act      = action_t'(in_action);
  assign is_eval  = accept && (act == ACT_EVAL);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_last_r <= LAST_W'(3);
      v_last_r <= LAST_W'(3);
      u_deg_r  <= DEG_W'(3);
      v_deg_r  <= DEG_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_U_LAST: u_last_r <= cfg_wdata[LAST_W-1:0];
        REG_V_LAST: v_last_r <= cfg_wdata[LAST_W-1:0];
        REG_U_DEG:  u_deg_r  <= cfg_wdata[DEG_W-1:0];
        REG_V_DEG:  v_deg_r  <= cfg_wdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Knot loads and basis start requests
  always_comb begin
    ukwr.we   = accept && (act == ACT_LOAD_U) && (in_entry_index < 10'(KNOT_DEPTH));
    ukwr.addr = in_entry_index[KADDR_W-1:0];
    ukwr.data = in_knot_value;
    vkwr.we   = accept && (act == ACT_LOAD_V) && (in_entry_index < 10'(KNOT_DEPTH));
    vkwr.addr = in_entry_index[KADDR_W-1:0];
    vkwr.data = in_knot_value;
    ustart.go    = is_eval;
    ustart.coord = in_u_coord;
    ustart.last  = u_last_r;
    ustart.deg   = u_deg_r;
    vstart.go    = is_eval;
    vstart.coord = in_v_coord;
    vstart.last  = v_last_r;
    vstart.deg   = v_deg_r;
  end

  bsev_basis u_basis (
    .clk     (clk),
    .rst_n   (rst_n),
    .kwr     (ukwr),
    .start   (ustart),
    .busy    (u_busy),
    .rd_addr ({1'b0, i_r}),
    .rd_data (nu_q)
  );

  bsev_basis v_basis (
    .clk     (clk),
    .rst_n   (rst_n),
    .kwr     (vkwr),
    .start   (vstart),
    .busy    (v_busy),
    .rd_addr ({1'b0, j_r}),
    .rd_data (nv_q)
  );

  // Control point memories
  assign cp_we = accept && (act == ACT_LOAD_P);

  always_ff @(posedge clk) begin
    if (cp_we) begin
      cx_mem[in_entry_index] <= in_point_x;
      cy_mem[in_entry_index] <= in_point_y;
      cz_mem[in_entry_index] <= in_point_z;
    end
    cx_q_r <= cx_mem[flat_r];
    cy_q_r <= cy_mem[flat_r];
    cz_q_r <= cz_mem[flat_r];
  end

  // Weight truncated toward zero after the Q15 rescale
  assign wbias = wprod_r + (wprod_r[2*BASIS_W-1] ? (2*BASIS_W)'(32767) : '0);
  assign w     = BASIS_W'(wbias >>> FRAC_BITS);

  function automatic logic signed [43:0] scale_term(logic signed [BASIS_W+POINT_W-1:0] p);
    logic signed [BASIS_W+POINT_W-1:0] pb;
    pb = p + (p[BASIS_W+POINT_W-1] ? (BASIS_W+POINT_W)'(32767) : '0);
    pb = pb >>> FRAC_BITS;
    return 44'(pb);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [43:0] a);
    if (a > 44'sd2147483647) return 32'sh7fffffff;
    if (a < -44'sd2147483648) return 32'sh80000000;
    return a[31:0];
  endfunction

  assign tx = w * cx_q_r;
  assign ty = w * cy_q_r;
  assign tz = w * cz_q_r;

  assign out_load = (state_r == T_OUT) && (!out_valid_r || !out_stall);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (is_eval) state_nxt = T_BASIS;
      T_BASIS: if (!u_busy && !v_busy) state_nxt = T_RD;
      T_RD:    state_nxt = T_WGT;
      T_WGT:   state_nxt = T_PRD;
      T_PRD:   state_nxt = T_ACC;
      T_ACC:   state_nxt = (j_r == v_last_r && i_r == u_last_r) ? T_OUT : T_RD;
      T_OUT:   if (out_load) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Multiply-accumulate datapath over the control grid, row by row
  always_ff @(posedge clk) begin
    unique case (state_r)
      T_IDLE: begin
        i_r    <= '0;
        j_r    <= '0;
        flat_r <= '0;
        ax_r   <= '0;
        ay_r   <= '0;
        az_r   <= '0;
      end
      T_BASIS, T_RD: ;
      T_WGT: wprod_r <= nu_q * nv_q;
      T_PRD: begin
        px_r <= tx;
        py_r <= ty;
        pz_r <= tz;
      end
      T_ACC: begin
        ax_r   <= ax_r + scale_term(px_r);
        ay_r   <= ay_r + scale_term(py_r);
        az_r   <= az_r + scale_term(pz_r);
        flat_r <= flat_r + CPADDR_W'(1);
        if (j_r == v_last_r) begin
          j_r <= '0;
          i_r <= i_r + LAST_W'(1);
        end else begin
          j_r <= j_r + LAST_W'(1);
        end
      end
      T_OUT: begin
        if (out_load) begin
          ox_r <= sat32(ax_r);
          oy_r <= sat32(ay_r);
          oz_r <= sat32(az_r);
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_surf_x = ox_r;
  assign out_surf_y = oy_r;
  assign out_surf_z = oz_r;

endmodule

`default_nettype wire

// ===== tb/bsev_checker.sv =====
// Checker for the B-spline surface evaluator: follows accepted beats on the
// input, result and configuration ports, predicts each surface point and compares.
// Depends on bsev_pkg for the action and register codes and the store geometry.
`default_nettype none

module bsev_checker import bsev_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         in_action,
  input  wire logic [9:0]         in_entry_index,
  input  wire logic [15:0]        in_knot_value,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic [15:0]        in_u_coord,
  input  wire logic [15:0]        in_v_coord,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] out_surf_x,
  input  wire logic signed [31:0] out_surf_y,
  input  wire logic signed [31:0] out_surf_z,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [4:0]         cfg_wdata,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam int     TLEN = MAX_CTRL_U + MAX_DEGREE + 2;

  typedef longint basis_row_t [TLEN];
  typedef logic [15:0] knot_list_t [KNOT_DEPTH];
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } surf_pt_t;

  logic [15:0]        u_knots [KNOT_DEPTH];
  logic [15:0]        v_knots [KNOT_DEPTH];
  logic signed [31:0] px [CP_DEPTH];
  logic signed [31:0] py [CP_DEPTH];
  logic signed [31:0] pz [CP_DEPTH];
  int                 m_last, n_last, p_deg, q_deg;
  surf_pt_t           surf_q [$];

  assign pending = surf_q.size();

  initial begin
    errors = 0;
    for (int i = 0; i < KNOT_DEPTH; i++) begin
      u_knots[i] = '0;
      v_knots[i] = '0;
    end
    for (int i = 0; i < CP_DEPTH; i++) begin
      px[i] = '0;
      py[i] = '0;
      pz[i] = '0;
    end
  end

  // Cox-de Boor basis over the clamped knot vector
  function automatic basis_row_t basis_at(input knot_list_t ks, input int last,
                                          input int deg, input longint u);
    longint     t [TLEN];
    basis_row_t nb;
    int         len, cnt;
    longint     a, b, d1, d2;
    bit         hit;
    len = last + deg + 2;
    for (int i = 0; i < TLEN; i++) begin
      nb[i] = 0;
      t[i]  = 0;
    end
    for (int i = 0; i < len; i++) begin
      if (i < deg) t[i] = 0;
      else if (i > last + 1) t[i] = 32768;
      else t[i] = longint'(ks[i - deg]);
    end
    for (int i = 0; i + 1 < len; i++) begin
      hit = (t[i] <= u && u < t[i+1]) ||
            (u == 32768 && t[i] < t[i+1] && t[i+1] == 32768);
      nb[i] = hit ? ONE : 0;
    end
    for (int d = 1; d <= deg; d++) begin
      cnt = len - 1 - d;
      for (int i = 0; i < cnt; i++) begin
        a = 0;
        b = 0;
        d1 = t[i+d] - t[i];
        d2 = t[i+d+1] - t[i+1];
        if (d1 != 0) a = ((u - t[i]) * nb[i]) / d1;
        if (d2 != 0) b = ((t[i+d+1] - u) * nb[i+1]) / d2;
        a = a + b;
        if (a > ONE) a = ONE;
        if (a < -ONE) a = -ONE;
        nb[i] = a;
      end
    end
    return nb;
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic surf_pt_t surface_at(input longint u, input longint v);
    basis_row_t nu, nv;
    longint     w, ax, ay, az;
    int         flat;
    surf_pt_t   r;
    nu = basis_at(u_knots, m_last, p_deg, u);
    nv = basis_at(v_knots, n_last, q_deg, v);
    ax = 0;
    ay = 0;
    az = 0;
    for (int i = 0; i <= m_last; i++) begin
      for (int j = 0; j <= n_last; j++) begin
        flat = i * (n_last + 1) + j;
        w = (nu[i] * nv[j]) / ONE;
        if (w != 0) begin
          ax += (w * longint'(px[flat])) / ONE;
          ay += (w * longint'(py[flat])) / ONE;
          az += (w * longint'(pz[flat])) / ONE;
        end
      end
    end
    r.x = sat32(ax);
    r.y = sat32(ay);
    r.z = sat32(az);
    return r;
  endfunction

  // Track configuration, loads and evaluations; compare result beats
  always @(posedge clk) begin
    surf_pt_t e;
    if (!rst_n) begin
      m_last <= 3;
      n_last <= 3;
      p_deg  <= 3;
      q_deg  <= 3;
      surf_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_U_LAST: m_last <= int'(cfg_wdata);
          REG_V_LAST: n_last <= int'(cfg_wdata);
          REG_U_DEG:  p_deg  <= int'(cfg_wdata[2:0]);
          REG_V_DEG:  q_deg  <= int'(cfg_wdata[2:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_LOAD_U: if (in_entry_index < KNOT_DEPTH) u_knots[in_entry_index] = in_knot_value;
          ACT_LOAD_V: if (in_entry_index < KNOT_DEPTH) v_knots[in_entry_index] = in_knot_value;
          ACT_LOAD_P: begin
            px[in_entry_index] = in_point_x;
            py[in_entry_index] = in_point_y;
            pz[in_entry_index] = in_point_z;
          end
          default: surf_q.push_back(surface_at(longint'(in_u_coord), longint'(in_v_coord)));
        endcase
      end
      if (out_valid && !out_stall) begin
        if (surf_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with no evaluation pending (%0d %0d %0d)",
                   $time, out_surf_x, out_surf_y, out_surf_z);
        end else begin
          e = surf_q.pop_front();
          if (out_surf_x !== e.x) begin
            errors++;
            $display("%0t: surf_x expected %0d actual %0d", $time, e.x, out_surf_x);
          end
          if (out_surf_y !== e.y) begin
            errors++;
            $display("%0t: surf_y expected %0d actual %0d", $time, e.y, out_surf_y);
          end
          if (out_surf_z !== e.z) begin
            errors++;
            $display("%0t: surf_z expected %0d actual %0d", $time, e.z, out_surf_z);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the surface evaluator testbench: clock, reset, stimulus and verdict.
// Depends on bsev_pkg, bspline_surface_evaluator and bsev_checker.
`default_nettype none

module testbench;
  import bsev_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 40000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_LOAD_U;
  logic [9:0]         in_entry_index = '0;
  logic [15:0]        in_knot_value = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic [15:0]        in_u_coord = '0;
  logic [15:0]        in_v_coord = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_surf_x, out_surf_y, out_surf_z;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_U_LAST;
  logic [4:0]         cfg_wdata = '0;
  int                 errors, pending;

  int  cyc = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  bit  pt_loaded [CP_DEPTH];
  logic [15:0] u_rec [KNOT_DEPTH];
  logic [15:0] v_rec [KNOT_DEPTH];
  int  cur_m, cur_n, cur_p, cur_q;

  always #5 clk = ~clk;

  bspline_surface_evaluator u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_entry_index, .in_knot_value,
    .in_point_x, .in_point_y, .in_point_z, .in_u_coord, .in_v_coord,
    .out_valid, .out_stall, .out_surf_x, .out_surf_y, .out_surf_z,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  bsev_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_entry_index, .in_knot_value,
    .in_point_x, .in_point_y, .in_point_z, .in_u_coord, .in_v_coord,
    .out_valid, .out_stall, .out_surf_x, .out_surf_y, .out_surf_z,
    .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  // Abort a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result-side stall: mostly short bursts, a few long ones
  always @(posedge clk) begin
    int r;
    if (stall_left != 0) stall_left <= stall_left - 1;
    else begin
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 8);
      end else if (r < 96) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(1, 4);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(20, 300);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  // Drive one beat and hold it until taken, then maybe idle
  task automatic push(input action_t act, input int idx, input int kv,
                      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                      input int uc, input int vc);
    int g;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_entry_index <= idx[9:0];
    in_knot_value  <= kv[15:0];
    in_point_x     <= x;
    in_point_y     <= y;
    in_point_z     <= z;
    in_u_coord     <= uc[15:0];
    in_v_coord     <= vc[15:0];
    do @(posedge clk); while (in_stall);
    g = pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_knot(input bit is_v, input int idx, input int kv);
    if (idx < KNOT_DEPTH) begin
      if (is_v) v_rec[idx] = kv[15:0];
      else u_rec[idx] = kv[15:0];
    end
    push(is_v ? ACT_LOAD_V : ACT_LOAD_U, idx, kv, $urandom, $urandom, $urandom,
         $urandom_range(0, 32768), $urandom_range(0, 32768));
  endtask

  function automatic logic [31:0] pick_point();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    if (r < 5) return $urandom;
    return 32'($signed($urandom_range(0, 2097152)) - 1048576);
  endfunction

  task automatic load_point(input int idx);
    pt_loaded[idx] = 1'b1;
    push(ACT_LOAD_P, idx, $urandom_range(0, 32768), pick_point(), pick_point(),
         pick_point(), $urandom_range(0, 32768), $urandom_range(0, 32768));
  endtask

  task automatic evaluate(input int uc, input int vc);
    push(ACT_EVAL, $urandom_range(0, 1023), $urandom_range(0, 32768), $urandom,
         $urandom, $urandom, uc, vc);
  endtask

  function automatic int pick_coord(input bit is_v);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 32768;
    if (r < 4) return is_v ? int'(v_rec[$urandom_range(0, KNOT_DEPTH-1)])
                           : int'(u_rec[$urandom_range(0, KNOT_DEPTH-1)]);
    return $urandom_range(0, 32768);
  endfunction

  // Nondecreasing knot list with some repeated knots
  task automatic load_sorted(input bit is_v, input int cnt);
    int val;
    val = 0;
    for (int s = 0; s < cnt; s++) begin
      if ($urandom_range(0, 4) != 0) val += $urandom_range(0, 65536 / (cnt + 1));
      if (val > 32768) val = 32768;
      load_knot(is_v, s, val);
    end
  endtask

  // Let the block drain before touching the registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_cfg(input int m, input int n, input int p, input int q);
    cur_m = m;
    cur_n = n;
    cur_p = p;
    cur_q = q;
    cfg_we    <= 1'b1;
    cfg_index <= REG_U_LAST;
    cfg_wdata <= m[4:0];
    @(posedge clk);
    cfg_index <= REG_V_LAST;
    cfg_wdata <= n[4:0];
    @(posedge clk);
    cfg_index <= REG_U_DEG;
    cfg_wdata <= p[4:0];
    @(posedge clk);
    cfg_index <= REG_V_DEG;
    cfg_wdata <= q[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Fill any grid entry the current setting reads but nobody wrote yet
  task automatic fill_grid();
    for (int i = 0; i < (cur_m + 1) * (cur_n + 1); i++)
      if (!pt_loaded[i]) load_point(i);
  endtask

  task automatic random_phase(input int nitems);
    int r;
    wait_idle();
    quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) == 0)
      set_cfg($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 7),
              $urandom_range(1, 7));
    else
      set_cfg($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3),
              $urandom_range(1, 3));
    fill_grid();
    if ($urandom_range(0, 2) != 0) begin
      load_sorted(1'b0, cur_m + 2);
      load_sorted(1'b1, cur_n + 2);
    end
    for (int k = 0; k < nitems; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) evaluate(pick_coord(1'b0), pick_coord(1'b1));
      else if (r < 62) load_point($urandom_range(0, (cur_m + 1) * (cur_n + 1) - 1));
      else if (r < 66) load_point($urandom_range(0, CP_DEPTH - 1));
      else if (r < 94) load_knot(r[0], $urandom_range(0, KNOT_DEPTH - 1),
                                 $urandom_range(0, 32768));
      else begin
        // out-of-range knot index: ignored, not counted
        load_knot(r[0], $urandom_range(KNOT_DEPTH, 1023), $urandom_range(0, 32768));
        k--;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CP_DEPTH; i++) pt_loaded[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: cubic 4x4 patch, knots with repeats, extreme coordinates
    set_cfg(3, 3, 3, 3);
    load_sorted(1'b0, KNOT_DEPTH);
    load_sorted(1'b1, KNOT_DEPTH);
    load_knot(1'b0, 1, u_rec[0]);
    fill_grid();
    evaluate(0, 0);
    evaluate(32768, 32768);
    evaluate(0, 32768);
    evaluate(int'(u_rec[1]), int'(v_rec[2]));
    evaluate(32768, 0);
    load_knot(1'b1, 40, 12345);
    evaluate(16384, 16384);

    // Directed: single point, degree zero
    wait_idle();
    set_cfg(0, 0, 0, 0);
    evaluate(0, 0);
    evaluate(32768, 32768);
    evaluate(16384, 100);

    // Directed: largest index and degree in each direction
    wait_idle();
    set_cfg(31, 1, 7, 1);
    fill_grid();
    evaluate(32768, 16384);
    evaluate(20000, 0);
    wait_idle();
    set_cfg(1, 31, 1, 7);
    fill_grid();
    evaluate(5, 32768);
    evaluate(32768, 32767);

    for (int ph = 0; ph < 12; ph++) random_phase(50);

    wait_idle();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/bsev_pkg.sv
sv/bsev_basis.sv
sv/bspline_surface_evaluator.sv
tb/bsev_checker.sv
tb/testbench.sv
